// ===== design/anlg_pkg.sv =====
// Shared types and constants for the angular normal loss gradient block.
`timescale 1ns / 1ps
`default_nettype none
package anlg_pkg;
  localparam int FRAC_BITS_DEF = 12;
  localparam int IN_W          = 18;
  // Square root unit: 50-bit radicands, 25-bit roots.
  localparam int SQ_W          = 50;
  localparam int RT_W          = SQ_W / 2;
  // Divider unit: four lanes, 48-bit numerator, 41-bit divisor, 32-bit quotient.
  localparam int DV_NW         = 48;
  localparam int DV_DW         = 41;
  localparam int DV_QW         = 32;
  localparam int DV_LANES      = 4;
  localparam int CFG_AW        = 1;
  localparam int CFG_DW        = 17;
  localparam logic [CFG_AW-1:0] REG_BATCH_COUNT = 1'b0;
  localparam logic [CFG_AW-1:0] REG_IGNORE_THR  = 1'b1;
  localparam logic [17:0] PI_Q16   = 18'd205887;
  localparam logic [24:0] EPS_Q24  = 25'd17;
  localparam logic [15:0] BC_RESET = 16'd1;
  localparam logic [16:0] THR_RESET = 17'd40960;

  typedef struct packed {
    logic signed [IN_W-1:0] pred_x;
    logic signed [IN_W-1:0] pred_y;
    logic signed [IN_W-1:0] pred_z;
    logic signed [IN_W-1:0] label_x;
    logic signed [IN_W-1:0] label_y;
    logic signed [IN_W-1:0] label_z;
    logic                   last;
  } pix_t;

  // Sideband carried alongside the square roots.
  typedef struct packed {
    logic [16:0]            poly;
    logic                   neg;
    logic                   ign;
    logic                   last;
    logic signed [IN_W-1:0] lab_x;
    logic signed [IN_W-1:0] lab_y;
    logic signed [IN_W-1:0] lab_z;
  } sq_pl_t;

  // Sideband carried alongside the divisions.
  typedef struct packed {
    logic       ign;
    logic       last;
    logic [2:0] lab_neg;
  } dv_pl_t;
endpackage
`default_nettype wire

// ===== design/anlg_front.sv =====
// Front pipeline: dot product, clamp, acos polynomial and radicands.
`timescale 1ns / 1ps
`default_nettype none
module anlg_front #(
  parameter int FRAC_BITS = anlg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire anlg_pkg::pix_t          pix,
  input  wire logic [16:0]             thr,
  output logic                         out_valid,
  output logic [anlg_pkg::SQ_W-1:0]    v1,
  output logic [anlg_pkg::SQ_W-1:0]    v2,
  output anlg_pkg::sq_pl_t             pl
);
  localparam int SH = 2 * FRAC_BITS - 16;
  localparam logic [37:0] ONE = 38'd1 << (2 * FRAC_BITS);

  // F1
  logic               f1_v;
  logic signed [35:0] f1_px, f1_py, f1_pz;
  anlg_pkg::sq_pl_t   f1_pl;
  // F2
  logic               f2_v;
  logic [16:0]        f2_t;
  anlg_pkg::sq_pl_t   f2_pl;
  anlg_pkg::sq_pl_t   f2_pl_next;
  // F3
  logic               f3_v;
  logic [16:0]        f3_t;
  logic [27:0]        f3_m1;
  logic [33:0]        f3_tt;
  anlg_pkg::sq_pl_t   f3_pl;
  // F4
  logic               f4_v;
  logic [16:0]        f4_t;
  logic [29:0]        f4_m2;
  logic [anlg_pkg::SQ_W-1:0] f4_v1, f4_v2;
  anlg_pkg::sq_pl_t   f4_pl;
  // F5
  logic               f5_v;
  logic [30:0]        f5_m3;
  logic [anlg_pkg::SQ_W-1:0] f5_v1, f5_v2;
  anlg_pkg::sq_pl_t   f5_pl;
  anlg_pkg::sq_pl_t   pl_next;

  logic [17:0]        lx_mag;
  logic signed [37:0] dot;
  logic [37:0]        dmag, dclamp;
  logic [12:0]        a_c;
  logic [13:0]        b_c;

  always_comb begin
    lx_mag = pix.label_x[17] ? 18'(-pix.label_x) : 18'(pix.label_x);
    dot    = 38'(f1_px) + 38'(f1_py) + 38'(f1_pz);
    dmag   = dot[37] ? 38'(-dot) : 38'(dot);
    dclamp = (dmag > ONE) ? ONE : dmag;
    a_c    = 13'd4867 - 13'(f3_m1[27:16]);
    b_c    = 14'd13901 - 14'(f4_m2[29:16]);
    f2_pl_next      = f1_pl;
    f2_pl_next.neg  = dot[37];
    pl_next         = f5_pl;
    pl_next.poly    = 17'd102940 - 17'(f5_m3[30:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0; f2_v <= 1'b0; f3_v <= 1'b0;
      f4_v <= 1'b0; f5_v <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      f1_v <= in_valid; f2_v <= f1_v; f3_v <= f2_v;
      f4_v <= f3_v; f5_v <= f4_v; out_valid <= f5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_px <= pix.pred_x * pix.label_x;
      f1_py <= pix.pred_y * pix.label_y;
      f1_pz <= pix.pred_z * pix.label_z;
      f1_pl.poly  <= '0;
      f1_pl.neg   <= 1'b0;
      f1_pl.ign   <= lx_mag > {1'b0, thr};
      f1_pl.last  <= pix.last;
      f1_pl.lab_x <= pix.label_x;
      f1_pl.lab_y <= pix.label_y;
      f1_pl.lab_z <= pix.label_z;

      f2_t  <= 17'(dclamp >> SH);
      f2_pl <= f2_pl_next;

      f3_t  <= f2_t;
      f3_m1 <= 28'(11'd1227 * f2_t);
      f3_tt <= 34'(f2_t * f2_t);
      f3_pl <= f2_pl;

      f4_t  <= f3_t;
      f4_m2 <= 30'(a_c * f3_t);
      f4_v1 <= anlg_pkg::SQ_W'(17'd65536 - f3_t) << 16;
      f4_v2 <= anlg_pkg::SQ_W'(34'h1_0000_0000 - f3_tt) << 16;
      f4_pl <= f3_pl;

      f5_m3 <= 31'(b_c * f4_t);
      f5_v1 <= f4_v1;
      f5_v2 <= f4_v2;
      f5_pl <= f4_pl;

      v1 <= f5_v1;
      v2 <= f5_v2;
      pl <= pl_next;
    end
  end
endmodule
`default_nettype wire

// ===== design/anlg_sqrt.sv =====
// Pipelined dual integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module anlg_sqrt #(
  parameter int W  = anlg_pkg::SQ_W,
  parameter int PW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [W-1:0]   a_in,
  input  wire logic [W-1:0]   b_in,
  input  wire logic [PW-1:0]  pl_in,
  output logic                out_valid,
  output logic [W/2-1:0]      a_root,
  output logic [W/2-1:0]      b_root,
  output logic [PW-1:0]       pl_out
);
  localparam int N  = W / 2;
  localparam int RW = N + 2;

  function automatic logic [RW+N-1:0] sq_step(input logic [RW-1:0] rem,
                                              input logic [N-1:0] root,
                                              input logic [1:0] bits);
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    cur   = {rem, bits};
    trial = {2'b00, root, 2'b01};
    if (cur >= trial) begin
      sq_step = {RW'(cur - trial), root[N-2:0], 1'b1};
    end else begin
      sq_step = {cur[RW-1:0], root[N-2:0], 1'b0};
    end
  endfunction

  logic              vld [N+1];
  logic [W-1:0]      av  [N+1];
  logic [W-1:0]      bv  [N+1];
  logic [RW-1:0]     ar  [N+1];
  logic [RW-1:0]     br  [N+1];
  logic [N-1:0]      aq  [N+1];
  logic [N-1:0]      bq  [N+1];
  logic [PW-1:0]     pl  [N+1];

  assign vld[0] = in_valid;
  assign av[0]  = a_in;
  assign bv[0]  = b_in;
  assign ar[0]  = '0;
  assign br[0]  = '0;
  assign aq[0]  = '0;
  assign bq[0]  = '0;
  assign pl[0]  = pl_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW+N-1:0] a_nx, b_nx;
    always_comb begin
      a_nx = sq_step(ar[k], aq[k], av[k][W-1:W-2]);
      b_nx = sq_step(br[k], bq[k], bv[k][W-1:W-2]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        av[k+1] <= av[k] << 2;
        bv[k+1] <= bv[k] << 2;
        ar[k+1] <= a_nx[RW+N-1:N];
        br[k+1] <= b_nx[RW+N-1:N];
        aq[k+1] <= a_nx[N-1:0];
        bq[k+1] <= b_nx[N-1:0];
        pl[k+1] <= pl[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign a_root    = aq[N];
  assign b_root    = bq[N];
  assign pl_out    = pl[N];
endmodule
`default_nettype wire

// ===== design/anlg_div.sv =====
// Pipelined multi-lane restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module anlg_div #(
  parameter int NW = anlg_pkg::DV_NW,
  parameter int DW = anlg_pkg::DV_DW,
  parameter int QW = anlg_pkg::DV_QW,
  parameter int L  = anlg_pkg::DV_LANES,
  parameter int PW = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [L-1:0][NW-1:0]    n_in,
  input  wire logic [L-1:0][DW-1:0]    d_in,
  input  wire logic [PW-1:0]           pl_in,
  output logic                         out_valid,
  output logic [L-1:0][QW-1:0]         q_out,
  output logic [L-1:0]                 ovf_out,
  output logic [PW-1:0]                pl_out
);
  logic                    vld [QW+1];
  logic [L-1:0][DW-1:0]    rem [QW+1];
  logic [L-1:0][QW-1:0]    low [QW+1];
  logic [L-1:0][QW-1:0]    quo [QW+1];
  logic [L-1:0][DW-1:0]    dv  [QW+1];
  logic [L-1:0]            ovf [QW+1];
  logic [PW-1:0]           pl  [QW+1];

  // Entry stage: high part becomes the first remainder; quotient overflow if
  // it already reaches the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < L; j++) begin
        rem[0][j] <= DW'(n_in[j] >> QW);
        low[0][j] <= n_in[j][QW-1:0];
        ovf[0][j] <= (n_in[j] >> QW) >= NW'(d_in[j]);
      end
      quo[0] <= '0;
      dv[0]  <= d_in;
      pl[0]  <= pl_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [L-1:0][DW:0]   cur;
    logic [L-1:0]         ge;
    always_comb begin
      for (int j = 0; j < L; j++) begin
        cur[j] = {rem[k][j], low[k][j][QW-1]};
        ge[j]  = cur[j] >= {1'b0, dv[k][j]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < L; j++) begin
          rem[k+1][j] <= ge[j] ? DW'(cur[j] - {1'b0, dv[k][j]}) : cur[j][DW-1:0];
          low[k+1][j] <= low[k][j] << 1;
          quo[k+1][j] <= {quo[k][j][QW-2:0], ge[j]};
        end
        dv[k+1]  <= dv[k];
        ovf[k+1] <= ovf[k];
        pl[k+1]  <= pl[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign q_out     = quo[QW];
  assign ovf_out   = ovf[QW];
  assign pl_out    = pl[QW];
endmodule
`default_nettype wire

// ===== design/angular_normal_loss_gradient.sv =====
// Top level of the angular normal loss gradient block.
// Pipeline order from input item to result item: front, square root,
// angle/accumulate, divide, output register.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds in place while a result waits on m_tready.
// Reset (rst, synchronous): empties the pipeline, clears the loss sum,
// batch_count returns to 1 and ignore_threshold to 40960.
`timescale 1ns / 1ps
`default_nettype none
module angular_normal_loss_gradient #(
  parameter int FRAC_BITS = anlg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Config write port
  input  wire logic                          cfg_we,
  input  wire logic [anlg_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [anlg_pkg::CFG_DW-1:0]   cfg_wdata,
  // Input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // tdata: pred_x, pred_y, pred_z, label_x, label_y, label_z (18b each), 4 zero
  input  wire logic [111:0]                  s_tdata,
  input  wire logic                          s_tlast,   // batch_end
  // Output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // tdata: grad_x, grad_y, grad_z, mean_loss (32b each)
  output logic [127:0]                       m_tdata,
  output logic                               m_tuser,   // pixel_ignored
  output logic                               m_tlast    // loss_valid
);
  localparam int SQ_PW = $bits(anlg_pkg::sq_pl_t);
  localparam int DV_PW = $bits(anlg_pkg::dv_pl_t);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] batch_count;
  logic [16:0] ignore_thr;
  logic [15:0] bc_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count <= anlg_pkg::BC_RESET;
      ignore_thr  <= anlg_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        anlg_pkg::REG_BATCH_COUNT: batch_count <= cfg_wdata[15:0];
        anlg_pkg::REG_IGNORE_THR:  ignore_thr  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A zero batch count divides as one.
  assign bc_eff = (batch_count == 16'd0) ? 16'd1 : batch_count;

  // ---------------------------------------------------------------------------
  // Global advance: every stage moves when the output register is free or
  // being drained. Nothing is dropped or duplicated on a stall.
  // ---------------------------------------------------------------------------
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  anlg_pkg::pix_t pix;
  always_comb begin
    pix.pred_x  = s_tdata[17:0];
    pix.pred_y  = s_tdata[35:18];
    pix.pred_z  = s_tdata[53:36];
    pix.label_x = s_tdata[71:54];
    pix.label_y = s_tdata[89:72];
    pix.label_z = s_tdata[107:90];
    pix.last    = s_tlast;
  end

  // ---------------------------------------------------------------------------
  // Front: dot product, clamp to [-1,1], acos polynomial, sqrt radicands
  // ---------------------------------------------------------------------------
  logic                       fr_v;
  logic [anlg_pkg::SQ_W-1:0]  fr_v1, fr_v2;
  anlg_pkg::sq_pl_t           fr_pl;

  anlg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .en,
    .in_valid (s_tvalid),
    .pix,
    .thr      (ignore_thr),
    .out_valid(fr_v),
    .v1       (fr_v1),
    .v2       (fr_v2),
    .pl       (fr_pl)
  );

  // ---------------------------------------------------------------------------
  // Square roots: s = sqrt(1-t) for acos, r = sqrt(1-t^2) for the gradient
  // ---------------------------------------------------------------------------
  logic                       sq_v;
  logic [anlg_pkg::RT_W-1:0]  s_root, r_root;
  logic [SQ_PW-1:0]           sq_plv;
  anlg_pkg::sq_pl_t           sq_pl;

  anlg_sqrt #(.W(anlg_pkg::SQ_W), .PW(SQ_PW)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (fr_v),
    .a_in     (fr_v1),
    .b_in     (fr_v2),
    .pl_in    (SQ_PW'(fr_pl)),
    .out_valid(sq_v),
    .a_root   (s_root),
    .b_root   (r_root),
    .pl_out   (sq_plv)
  );
  assign sq_pl = anlg_pkg::sq_pl_t'(sq_plv);

  // ---------------------------------------------------------------------------
  // B1: acos magnitude = s*p >> 16, denominator = (r + eps) * batch_count
  // B2: fold sign (pi - angle for a negative dot)
  // ---------------------------------------------------------------------------
  logic              b1_v, b2_v;
  logic [17:0]       b1_ang;
  logic [40:0]       b1_den, b2_den;
  anlg_pkg::sq_pl_t  b1_pl, b2_pl;
  logic [17:0]       b2_ang;
  logic [41:0]       ang_prod;

  assign ang_prod = 42'(s_root * sq_pl.poly);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
    end else if (en) begin
      b1_v <= sq_v;
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_ang <= ang_prod[33:16];
      b1_den <= 41'((r_root + anlg_pkg::EPS_Q24) * bc_eff);
      b1_pl  <= sq_pl;
      b2_ang <= b1_pl.neg ? (anlg_pkg::PI_Q16 - b1_ang) : b1_ang;
      b2_den <= b1_den;
      b2_pl  <= b1_pl;
    end
  end

  // ---------------------------------------------------------------------------
  // Loss accumulator: saturates at 2^48-1, cleared after the batch-end item.
  // The sum including the current item feeds the mean divider lane.
  // ---------------------------------------------------------------------------
  logic [47:0] loss_sum;
  logic [48:0] loss_add;
  logic [47:0] loss_after;

  always_comb begin
    loss_add = {1'b0, loss_sum} + 49'(b2_ang);
    if (b2_pl.ign) begin
      loss_after = loss_sum;
    end else if (loss_add[48]) begin
      loss_after = '1;
    end else begin
      loss_after = loss_add[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_sum <= '0;
    end else if (en && b2_v) begin
      loss_sum <= b2_pl.last ? 48'd0 : loss_after;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: lanes 0-2 are |label| << 24 over the denominator, lane 3 the
  // loss sum over batch_count.
  // ---------------------------------------------------------------------------
  logic [anlg_pkg::DV_LANES-1:0][anlg_pkg::DV_NW-1:0] dv_n;
  logic [anlg_pkg::DV_LANES-1:0][anlg_pkg::DV_DW-1:0] dv_d;
  logic [17:0]       lab_mag [3];
  logic [2:0]        lab_neg;
  anlg_pkg::dv_pl_t  dv_in_pl;

  always_comb begin
    lab_neg[0] = b2_pl.lab_x[17];
    lab_neg[1] = b2_pl.lab_y[17];
    lab_neg[2] = b2_pl.lab_z[17];
    lab_mag[0] = lab_neg[0] ? 18'(-b2_pl.lab_x) : 18'(b2_pl.lab_x);
    lab_mag[1] = lab_neg[1] ? 18'(-b2_pl.lab_y) : 18'(b2_pl.lab_y);
    lab_mag[2] = lab_neg[2] ? 18'(-b2_pl.lab_z) : 18'(b2_pl.lab_z);
    for (int j = 0; j < 3; j++) begin
      dv_n[j] = anlg_pkg::DV_NW'({lab_mag[j], 24'd0});
      dv_d[j] = b2_den;
    end
    dv_n[3] = loss_after;
    dv_d[3] = anlg_pkg::DV_DW'(bc_eff);
    dv_in_pl.ign     = b2_pl.ign;
    dv_in_pl.last    = b2_pl.last;
    dv_in_pl.lab_neg = lab_neg;
  end

  logic                                               dv_v;
  logic [anlg_pkg::DV_LANES-1:0][anlg_pkg::DV_QW-1:0] dv_q;
  logic [anlg_pkg::DV_LANES-1:0]                      dv_ovf;
  logic [DV_PW-1:0]                                   dv_plv;
  anlg_pkg::dv_pl_t                                   dv_pl;

  anlg_div #(
    .NW(anlg_pkg::DV_NW), .DW(anlg_pkg::DV_DW), .QW(anlg_pkg::DV_QW),
    .L(anlg_pkg::DV_LANES), .PW(DV_PW)
  ) u_div (
    .clk, .rst, .en,
    .in_valid (b2_v),
    .n_in     (dv_n),
    .d_in     (dv_d),
    .pl_in    (DV_PW'(dv_in_pl)),
    .out_valid(dv_v),
    .q_out    (dv_q),
    .ovf_out  (dv_ovf),
    .pl_out   (dv_plv)
  );
  assign dv_pl = anlg_pkg::dv_pl_t'(dv_plv);

  // ---------------------------------------------------------------------------
  // Output: gradient sign opposite the label, saturated to 32 bits signed;
  // mean saturated to 32 bits unsigned and shown only at batch end.
  // ---------------------------------------------------------------------------
  logic [31:0] grad [3];
  logic [31:0] mean;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dv_pl.ign) begin
        grad[j] = '0;
      end else if (dv_pl.lab_neg[j]) begin
        grad[j] = (dv_ovf[j] || dv_q[j] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : dv_q[j];
      end else if (dv_ovf[j] || dv_q[j] > 32'h8000_0000) begin
        grad[j] = 32'h8000_0000;
      end else begin
        grad[j] = 32'd0 - dv_q[j];
      end
    end
    if (!dv_pl.last) begin
      mean = '0;
    end else begin
      mean = dv_ovf[3] ? 32'hFFFF_FFFF : dv_q[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {mean, grad[2], grad[1], grad[0]};
      m_tuser <= dv_pl.ign;
      m_tlast <= dv_pl.last;
    end
  end
endmodule
`default_nettype wire
